@@ sv/shod_pkg.sv @@
// Package for the state history oscillation detector.
// Holds the command codes, configuration indexes, beat structs and helpers.
// No dependencies.
`timescale 1ns / 1ps

package shod_pkg;

    localparam int unsigned HIST_DEPTH = 16;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam int unsigned CNT_W      = $clog2(HIST_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TAKE  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_MIN_CYCLES = 3'd0,
        CFG_WINDOW_MS  = 3'd1,
        CFG_OFF_CODE   = 3'd2,
        CFG_INIT_CODE  = 3'd3,
        CFG_FAULT_CODE = 3'd4
    } t_cfg_idx;

    localparam logic [6:0]  MIN_CYCLES_RST = 7'd3;
    localparam logic [31:0] WINDOW_MS_RST  = 32'd60000;
    localparam logic [3:0]  OFF_CODE_RST   = 4'd0;
    localparam logic [3:0]  INIT_CODE_RST  = 4'd1;
    localparam logic [3:0]  FAULT_CODE_RST = 4'd15;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  state_code;
        logic [31:0] entered_ms;
        logic [7:0]  read_index;
    } t_item;

    typedef struct packed {
        logic        entry_valid;
        logic [3:0]  entry_state;
        logic [31:0] entry_time_ms;
        logic [4:0]  history_count;
        logic        oscillation_flag;
    } t_result;

    function automatic logic f_excluded(
        input logic [3:0] code,
        input logic [3:0] off_c,
        input logic [3:0] init_c,
        input logic [3:0] fault_c
    );
        return (code == off_c) || (code == init_c) || (code == fault_c);
    endfunction

endpackage

@@ sv/state_history_oscillation_detector.sv @@
// Top level of the state history oscillation detector.
// Ring of 16 state entries in one synchronous memory plus a scan sequencer.
// Depends on shod_pkg.
`timescale 1ns / 1ps

// Commands are taken on start while busy is low; every command gives one result beat on
// o_done for exactly one cycle, which the receiver must take. Take, reset and a read past
// the stored count, and a push without a full window or with min_cycles zero, give it in
// the cycle after the command; a valid read goes through one memory read and S_READ. A
// scanning push reads the newest 2*min_cycles entries through the single memory read
// port, one entry per cycle, and ends after the last one or when an entry breaks the
// alternation. The memory is never cleared; only written entries are read.
module state_history_oscillation_detector import shod_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    logic [35:0] mem [HIST_DEPTH];
    logic [35:0] r_rd;

    t_state             r_state;
    logic [HIST_AW-1:0] r_head;
    logic [CNT_W-1:0]   r_count;
    logic               r_flag;
    logic [6:0]         r_min_cycles;
    logic [31:0]        r_window_ms;
    logic [3:0]         r_off_code;
    logic [3:0]         r_init_code;
    logic [3:0]         r_fault_code;
    logic [CNT_W-1:0]   r_age;
    logic [CNT_W-1:0]   r_win_last;
    logic               r_rd_vld;
    logic [CNT_W-1:0]   r_rd_age;
    logic [3:0]         r_even;
    logic [3:0]         r_odd;
    logic [31:0]        r_t0;
    logic               r_done;
    t_result            r_res;

    logic               accept;
    logic               mem_we;
    logic               mem_re;
    logic [HIST_AW-1:0] mem_raddr;
    logic               scan_issue;
    logic [CNT_W-1:0]   n_count;
    logic [7:0]         win;
    logic               scan_go;
    logic               rd_ok;
    logic [3:0]         rd_code;
    logic [31:0]        rd_time;
    logic [31:0]        span;
    logic               chk_fail;
    logic               chk_last;
    logic               chk_hit;
    logic [3:0]         want;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_res;

    assign mem_we     = accept && (i_item.cmd == CMD_PUSH);
    assign scan_issue = (r_state == S_SCAN) && (r_age <= r_win_last);
    assign rd_ok      = {3'b000, r_count} > i_item.read_index;
    assign mem_re     = scan_issue || (accept && (i_item.cmd == CMD_READ) && rd_ok);
    assign mem_raddr  = (r_state == S_SCAN)
                      ? r_head - 1'b1 - r_age[HIST_AW-1:0]
                      : r_head - 1'b1 - i_item.read_index[HIST_AW-1:0];

    assign n_count = (r_count == CNT_W'(HIST_DEPTH)) ? r_count : r_count + 1'b1;
    assign win     = {r_min_cycles, 1'b0};
    assign scan_go = (r_min_cycles != 7'd0) && ({3'b000, n_count} >= win);

    assign rd_code = r_rd[35:32];
    assign rd_time = r_rd[31:0];
    assign span    = r_t0 - rd_time;
    assign want    = r_rd_age[0] ? r_odd : r_even;

    always_comb begin
        chk_fail = 1'b0;
        if (r_rd_age == '0) begin
            chk_fail = 1'b0;
        end else if (r_rd_age == CNT_W'(1)) begin
            chk_fail = (rd_code == r_even)
                    || f_excluded(rd_code, r_off_code, r_init_code, r_fault_code)
                    || f_excluded(r_even, r_off_code, r_init_code, r_fault_code);
        end else begin
            chk_fail = (rd_code != want);
        end
        if (!chk_fail && (r_rd_age == r_win_last) && (span > r_window_ms)) begin
            chk_fail = 1'b1;
        end
    end

    assign chk_last = r_rd_vld && (r_rd_age == r_win_last);
    assign chk_hit  = chk_last && !chk_fail;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_head] <= {i_item.state_code, i_item.entered_ms};
        end
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_flag       <= 1'b0;
            r_min_cycles <= MIN_CYCLES_RST;
            r_window_ms  <= WINDOW_MS_RST;
            r_off_code   <= OFF_CODE_RST;
            r_init_code  <= INIT_CODE_RST;
            r_fault_code <= FAULT_CODE_RST;
            r_age        <= '0;
            r_win_last   <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_age     <= '0;
            r_even       <= '0;
            r_odd        <= '0;
            r_t0         <= '0;
            r_done       <= 1'b0;
            r_res        <= '0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= scan_issue;
            r_rd_age <= r_age;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_CYCLES: r_min_cycles <= i_cfg_data[6:0];
                    CFG_WINDOW_MS:  r_window_ms  <= i_cfg_data;
                    CFG_OFF_CODE:   r_off_code   <= i_cfg_data[3:0];
                    CFG_INIT_CODE:  r_init_code  <= i_cfg_data[3:0];
                    CFG_FAULT_CODE: r_fault_code <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res <= '0;
                        unique case (i_item.cmd)
                            CMD_PUSH: begin
                                r_head  <= r_head + 1'b1;
                                r_count <= n_count;
                                if (scan_go) begin
                                    r_state    <= S_SCAN;
                                    r_age      <= '0;
                                    r_win_last <= win[CNT_W-1:0] - 1'b1;
                                end else begin
                                    r_done                 <= 1'b1;
                                    r_res.history_count    <= n_count;
                                    r_res.oscillation_flag <= r_flag;
                                end
                            end
                            CMD_READ: begin
                                if (rd_ok) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_done                 <= 1'b1;
                                    r_res.history_count    <= r_count;
                                    r_res.oscillation_flag <= r_flag;
                                end
                            end
                            CMD_TAKE: begin
                                r_flag                 <= 1'b0;
                                r_done                 <= 1'b1;
                                r_res.history_count    <= r_count;
                                r_res.oscillation_flag <= r_flag;
                            end
                            CMD_RESET: begin
                                r_head  <= '0;
                                r_count <= '0;
                                r_flag  <= 1'b0;
                                r_done  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state                <= S_IDLE;
                    r_done                 <= 1'b1;
                    r_res.entry_valid      <= 1'b1;
                    r_res.entry_state      <= rd_code;
                    r_res.entry_time_ms    <= rd_time;
                    r_res.history_count    <= r_count;
                    r_res.oscillation_flag <= r_flag;
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_age <= r_age + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (r_rd_age == '0) begin
                            r_even <= rd_code;
                            r_t0   <= rd_time;
                        end
                        if (r_rd_age == CNT_W'(1)) begin
                            r_odd <= rd_code;
                        end
                        if (chk_fail || chk_last) begin
                            r_state                <= S_IDLE;
                            r_done                 <= 1'b1;
                            r_flag                 <= r_flag || chk_hit;
                            r_res.history_count    <= r_count;
                            r_res.oscillation_flag <= r_flag || chk_hit;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/shod_checker.sv @@
// Port-level checks for the state history oscillation detector.
// Bound to the top level; depends on shod_pkg.
`timescale 1ns / 1ps

module shod_checker import shod_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input t_result     o_result
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted beat produced neither busy nor a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.entry_valid |->
            (o_result.entry_state == 4'd0) && (o_result.entry_time_ms == 32'd0))
        else $error("invalid entry carries nonzero fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.history_count <= 5'(HIST_DEPTH))
                && (!o_result.entry_valid || (o_result.history_count != 5'd0)))
        else $error("history count out of range");

endmodule

bind state_history_oscillation_detector shod_checker u_shod_checker (.*);
